// ===== design/sbpl_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpl_pkg
// Shared types and constants for the sorted bounded priority list.
// ----------------------------------------------------------------------------
package sbpl_pkg;

    localparam int ACT_W      = 3;
    localparam int IDX_W      = 31;
    localparam int KEY_W      = 32;
    localparam int RC_W       = 6;
    localparam int STS_W      = 2;
    localparam int CNT_OUT_W  = 6;
    localparam int TDATA_W    = 72;
    // Longest readout burst, in beats.
    localparam int RESULT_LIMIT = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_TOP   = 3'd2,
        ACT_SIZE  = 3'd3,
        ACT_READ  = 3'd4,
        ACT_CLEAR = 3'd5
    } t_action;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;  // capture the incoming command beat
        logic exec;  // carry out the captured command
        logic step;  // emit the next readout entry
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic    out_free;  // output register can take a result this cycle
        t_action action;    // captured command
        logic    rd_zero;   // readout would return no entries
        logic    rd_last;   // current readout entry is the final one
    } t_dp_stat;

endpackage

// ===== design/sorted_bounded_priority_list.sv =====
// ----------------------------------------------------------------------------
// sorted_bounded_priority_list
// Bounded candidate list for nearest-neighbor search, kept sorted by key.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH (index, key) entries in ascending key order and
// takes one command per input beat: push, pop largest, top largest, size,
// read out, or clear. Keys are 32-bit unsigned, so fixed-point distances and
// the bit patterns of non-negative floats both order correctly. A push lands
// before the first entry whose key is not below its own, except that a tie
// with the head places it just after the head; a push to a full list is
// rejected with a full status, and pop or top on an empty list return an
// empty status. Every command yields one output beat, but a read out with
// entries yields one beat per leading entry (at most 32), tlast on the final one.
// Timing: each command is captured in the idle state and carried out in the
// exec state once the output register is free; a read out then streams its
// entries one beat per cycle, while the output side is ready, through the
// single read port over the entry cells. A push compares the new key against
// every cell at once and shifts the tail of the list in parallel. The output
// register lets the next command be taken while a result beat still waits.
// ----------------------------------------------------------------------------
module sorted_bounded_priority_list
    import sbpl_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command stream.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: point_index [30:0], key [62:31], read_count [68:63], zero pad.
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // tuser: action [2:0].
    input  logic [ACT_W-1:0]   s_axis_tuser,
    // Result stream.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // tdata: out_index [30:0], out_key [62:31], entry_count [68:63], zero pad.
    output logic [TDATA_W-1:0] m_axis_tdata,
    // tuser: status [1:0].
    output logic [STS_W-1:0]   m_axis_tuser,
    output logic               m_axis_tlast
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic [IDX_W-1:0]     out_index;
    logic [KEY_W-1:0]     out_key;
    logic [CNT_OUT_W-1:0] out_count;

    // The sequencer decides when a beat is captured, executed, or streamed.
    sbpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // The datapath owns the sorted cells and the output register.
    sbpl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_in_action     (s_axis_tuser),
        .i_in_index      (s_axis_tdata[IDX_W-1:0]),
        .i_in_key        (s_axis_tdata[IDX_W+KEY_W-1:IDX_W]),
        .i_in_read_count (s_axis_tdata[IDX_W+KEY_W+RC_W-1:IDX_W+KEY_W]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_out_status    (m_axis_tuser),
        .o_out_index     (out_index),
        .o_out_key       (out_key),
        .o_out_count     (out_count),
        .o_out_last      (m_axis_tlast)
    );

    // Pack the result fields from the lowest bit up, zero filled to bytes.
    assign m_axis_tdata = {{(TDATA_W-IDX_W-KEY_W-CNT_OUT_W){1'b0}},
                           out_count, out_key, out_index};

endmodule

// ===== design/sbpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbpl_ctrl
// Command sequencer: capture, execute, and readout burst control.
// ----------------------------------------------------------------------------
module sbpl_ctrl
    import sbpl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    if (i_stat.action == ACT_READ && !i_stat.rd_zero) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                if (i_stat.out_free && i_stat.rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            S_READ: begin
                o_cmd.step = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // A readout burst is only entered for a readout command with entries.
    a_read_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && n_state == S_READ) |->
            (i_stat.action == ACT_READ && !i_stat.rd_zero))
        else $error("readout burst entered for a command with no entries");

    // A command is never executed twice.
    a_single_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec)
        else $error("command executed on consecutive cycles");

    // Nothing is captured while a command is still in progress.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec || o_cmd.step) |-> !o_cmd.load)
        else $error("command captured while busy");

endmodule

// ===== design/sbpl_dp.sv =====
// ----------------------------------------------------------------------------
// sbpl_dp
// Sorted entry cells with parallel compare-and-shift insert, command
// register, readout pointer and output register.
// ----------------------------------------------------------------------------
module sbpl_dp
    import sbpl_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [ACT_W-1:0]     i_in_action,
    input  logic [IDX_W-1:0]     i_in_index,
    input  logic [KEY_W-1:0]     i_in_key,
    input  logic [RC_W-1:0]      i_in_read_count,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STS_W-1:0]     o_out_status,
    output logic [IDX_W-1:0]     o_out_index,
    output logic [KEY_W-1:0]     o_out_key,
    output logic [CNT_OUT_W-1:0] o_out_count,
    output logic                 o_out_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Captured command.
    t_action         r_cmd_action;
    logic [IDX_W-1:0] r_cmd_index;
    logic [KEY_W-1:0] r_cmd_key;
    logic [RC_W-1:0]  r_cmd_rc;

    // Entry cells, sorted by nondecreasing key below r_count.
    logic [KEY_W-1:0] r_key [DEPTH];
    logic [IDX_W-1:0] r_idx [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    // Readout state.
    logic [AW-1:0]    r_rd_ptr;
    logic [RC_W-1:0]  r_rd_len;

    // Output register.
    logic             r_out_valid;
    logic [STS_W-1:0] r_out_status;
    logic [IDX_W-1:0] r_out_index;
    logic [KEY_W-1:0] r_out_key;
    logic [CW-1:0]    r_out_count;
    logic             r_out_last;

    logic             out_free;
    logic             full;
    logic             empty;
    logic             do_push;
    logic [DEPTH-1:0] shift_at;
    logic             head_first;
    logic [6:0]       rd_n;
    logic [6:0]       cnt7;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_key;
    logic [IDX_W-1:0] rd_idx;
    logic [6:0]       ptr_next7;

    assign out_free = !r_out_valid || i_out_ready;
    assign full     = (r_count >= CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign do_push  = i_cmd.exec && (r_cmd_action == ACT_PUSH) && !full;

    // Insert position: the new entry heads the list when the list is empty
    // or the head key is larger; otherwise it lands before the first later
    // entry whose key is not below the new key. Since the list is sorted,
    // the cells at or after that position form a suffix.
    assign head_first = empty || (r_key[0] > r_cmd_key);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                shift_at[i] = head_first;
            end else begin
                shift_at[i] = head_first || (CW'(i) >= r_count) ||
                              (r_key[i] >= r_cmd_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (do_push && shift_at[i]) begin
                if (i == 0) begin
                    r_key[i] <= r_cmd_key;
                    r_idx[i] <= r_cmd_index;
                end else if (!shift_at[i-1]) begin
                    r_key[i] <= r_cmd_key;
                    r_idx[i] <= r_cmd_index;
                end else begin
                    r_key[i] <= r_key[i-1];
                    r_idx[i] <= r_idx[i-1];
                end
            end
        end
    end

    // Readout length: the smallest of the request, the count and the limit.
    assign cnt7 = 7'(r_count);
    always_comb begin
        rd_n = {1'b0, r_cmd_rc};
        if (cnt7 < rd_n) begin
            rd_n = cnt7;
        end
        if (7'(RESULT_LIMIT) < rd_n) begin
            rd_n = 7'(RESULT_LIMIT);
        end
    end

    assign ptr_next7 = {{(7-AW){1'b0}}, r_rd_ptr} + 7'd1;

    // One read port over the cells: the tail entry for top, else the pointer.
    assign rd_addr = (r_cmd_action == ACT_TOP) ? AW'(r_count - 1'b1) : r_rd_ptr;
    assign rd_key  = r_key[rd_addr];
    assign rd_idx  = r_idx[rd_addr];

    always_comb begin
        n_count = r_count;
        if (i_cmd.exec) begin
            case (r_cmd_action)
                ACT_PUSH:  if (!full)  n_count = r_count + 1'b1;
                ACT_POP:   if (!empty) n_count = r_count - 1'b1;
                ACT_CLEAR: n_count = '0;
                default:   n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.step ||
                (i_cmd.exec && !(r_cmd_action == ACT_READ && rd_n != 7'd0))) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_action <= t_action'(i_in_action);
            r_cmd_index  <= i_in_index;
            r_cmd_key    <= i_in_key;
            r_cmd_rc     <= i_in_read_count;
        end

        if (i_cmd.exec) begin
            r_rd_ptr     <= '0;
            r_rd_len     <= rd_n[RC_W-1:0];
            r_out_status <= STS_OK;
            r_out_index  <= '0;
            r_out_key    <= '0;
            r_out_count  <= n_count;
            r_out_last   <= 1'b1;
            unique case (r_cmd_action)
                ACT_PUSH: begin
                    if (full) begin
                        r_out_status <= STS_FULL;
                    end
                end
                ACT_POP: begin
                    if (empty) begin
                        r_out_status <= STS_EMPTY;
                    end
                end
                ACT_TOP: begin
                    if (empty) begin
                        r_out_status <= STS_EMPTY;
                    end else begin
                        r_out_index <= rd_idx;
                        r_out_key   <= rd_key;
                    end
                end
                ACT_READ: begin
                    if (empty) begin
                        r_out_status <= STS_EMPTY;
                    end
                end
                default: begin
                    r_out_status <= STS_OK;
                end
            endcase
        end else if (i_cmd.step) begin
            r_rd_ptr     <= ptr_next7[AW-1:0];
            r_out_status <= STS_OK;
            r_out_index  <= rd_idx;
            r_out_key    <= rd_key;
            r_out_count  <= r_count;
            r_out_last   <= (ptr_next7 == {1'b0, r_rd_len});
        end
    end

    assign o_stat.out_free = out_free;
    assign o_stat.action   = r_cmd_action;
    assign o_stat.rd_zero  = (rd_n == 7'd0);
    assign o_stat.rd_last  = (ptr_next7 == {1'b0, r_rd_len});

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_index  = r_out_index;
    assign o_out_key    = r_out_key;
    assign o_out_count  = CNT_OUT_W'(7'(r_out_count));
    assign o_out_last   = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not add an entry");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_cmd_action == ACT_CLEAR) |=> r_count == '0)
        else $error("clear left entries behind");

    for (genvar g = 1; g < DEPTH; g++) begin : g_order_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_count > CW'(g)) |-> (r_key[g-1] <= r_key[g]))
            else $error("entry keys out of order");
    end

endmodule

// ===== tb/tb_sorted_bounded_priority_list.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_bounded_priority_list
// Self-checking bench for the sorted candidate list of the neighbor search.
// ----------------------------------------------------------------------------
// Commands are queued per phase by an initial block. A clocked driver sends
// them as command beats, and a clocked monitor checks every result beat.
// Each accepted command runs through a behavioral copy of the list held in
// the bench. That copy yields the result beats it should cause, and the
// monitor compares them field by field, in order. The run starts with a
// directed set of corner cases. Random traffic follows in four idling
// phases: none, sender gaps, receiver stalls, then both at a light rate.
// Some phases fill the list to the brim so that full pushes and long
// read outs get exercised.
// ----------------------------------------------------------------------------
module tb_sorted_bounded_priority_list;
    import sbpl_pkg::*;

    localparam int LIST_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to keep watching for stray beats once every result has arrived.
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        t_action              action;
        logic [IDX_W-1:0]     point_index;
        logic [KEY_W-1:0]     key;
        logic [RC_W-1:0]      read_count;
    } list_cmd_t;

    typedef struct {
        logic [STS_W-1:0]     status;
        logic [IDX_W-1:0]     out_index;
        logic [KEY_W-1:0]     out_key;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 last;
    } list_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // tdata: point_index [30:0], key [62:31], read_count [68:63], zero pad.
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    // tuser: action [2:0].
    logic [ACT_W-1:0]   s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // tdata: out_index [30:0], out_key [62:31], entry_count [68:63], zero pad.
    logic [TDATA_W-1:0] m_axis_tdata;
    // tuser: status [1:0].
    logic [STS_W-1:0]   m_axis_tuser;
    logic               m_axis_tlast;

    sorted_bounded_priority_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Commands waiting to be sent, and result beats still owed by the block.
    list_cmd_t    pending_cmds[$];
    list_result_t owed_results[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Count of entries the list will hold once everything queued so far has
    // run. The generator uses it to aim read outs and fills.
    int planned_count = 0;

    // ------------------------------------------------------------------------
    // Behavioral copy of the list.
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0] held_keys[LIST_DEPTH];
    logic [IDX_W-1:0] held_indices[LIST_DEPTH];
    int               held_count = 0;

    // Entry count on a result beat is the count after the command has run.
    function automatic void owe_result(logic [STS_W-1:0] status,
                                       logic [IDX_W-1:0] idx,
                                       logic [KEY_W-1:0] key, logic last);
        list_result_t r;
        r.status      = status;
        r.out_index   = idx;
        r.out_key     = key;
        r.entry_count = CNT_OUT_W'(held_count);
        r.last        = last;
        owed_results.push_back(r);
    endfunction

    function automatic void run_list_command(list_cmd_t c);
        int pos;
        int n;
        pos = 0;
        n   = 0;
        case (c.action)
            ACT_PUSH: begin
                if (held_count >= LIST_DEPTH) begin
                    owe_result(STS_FULL, '0, '0, 1'b1);
                end else begin
                    // A key equal to the head's lands right behind the head;
                    // otherwise it goes before the first key not below it.
                    if (held_count != 0 && !(held_keys[0] > c.key)) begin
                        pos = 1;
                        while (pos < held_count && held_keys[pos] < c.key)
                            pos++;
                    end
                    for (int i = held_count; i > pos; i--) begin
                        held_keys[i]    = held_keys[i-1];
                        held_indices[i] = held_indices[i-1];
                    end
                    held_keys[pos]    = c.key;
                    held_indices[pos] = c.point_index;
                    held_count++;
                    owe_result(STS_OK, '0, '0, 1'b1);
                end
            end
            ACT_POP: begin
                // The removed entry is not reported.
                if (held_count == 0) begin
                    owe_result(STS_EMPTY, '0, '0, 1'b1);
                end else begin
                    held_count--;
                    owe_result(STS_OK, '0, '0, 1'b1);
                end
            end
            ACT_TOP: begin
                if (held_count == 0)
                    owe_result(STS_EMPTY, '0, '0, 1'b1);
                else
                    owe_result(STS_OK, held_indices[held_count-1],
                               held_keys[held_count-1], 1'b1);
            end
            ACT_READ: begin
                n = int'(c.read_count);
                if (n > held_count)
                    n = held_count;
                if (n > RESULT_LIMIT)
                    n = RESULT_LIMIT;
                if (n == 0) begin
                    owe_result(held_count == 0 ? STS_EMPTY : STS_OK, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        owe_result(STS_OK, held_indices[i], held_keys[i], i == n - 1);
                end
            end
            ACT_CLEAR: begin
                held_count = 0;
                owe_result(STS_OK, '0, '0, 1'b1);
            end
            default: begin
                // Size needs nothing beyond the entry count on the beat.
                owe_result(STS_OK, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Command generation.
    // ------------------------------------------------------------------------
    function automatic void queue_cmd(t_action act, logic [IDX_W-1:0] idx,
                                      logic [KEY_W-1:0] key, int rc);
        list_cmd_t c;
        c.action      = act;
        c.point_index = idx;
        c.key         = key;
        c.read_count  = RC_W'(rc);
        pending_cmds.push_back(c);
        queued_count++;
        case (act)
            ACT_PUSH:  if (planned_count < LIST_DEPTH) planned_count++;
            ACT_POP:   if (planned_count > 0) planned_count--;
            ACT_CLEAR: planned_count = 0;
            default:   ;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        return IDX_W'($urandom());
    endfunction

    // Small keys are favored so that ties, also with the head, come often.
    // The non-negative float patterns share the same unsigned order.
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_W'($urandom_range(0, 15));
            5:       return $urandom() & 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic int rand_read_count();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, RESULT_LIMIT);
            1:       return planned_count;
            2:       return RESULT_LIMIT;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // Fields a command does not use still carry random bits.
    function automatic void queue_random_cmds(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_cmd(ACT_PUSH, rand_index(), rand_key(), $urandom_range(0, 32));
            else if (pick < 62)
                queue_cmd(ACT_POP, rand_index(), rand_key(), $urandom_range(0, 32));
            else if (pick < 72)
                queue_cmd(ACT_TOP, rand_index(), rand_key(), $urandom_range(0, 32));
            else if (pick < 78)
                queue_cmd(ACT_SIZE, rand_index(), rand_key(), $urandom_range(0, 32));
            else if (pick < 96)
                queue_cmd(ACT_READ, rand_index(), rand_key(), rand_read_count());
            else
                queue_cmd(ACT_CLEAR, rand_index(), rand_key(), $urandom_range(0, 32));
        end
    endfunction

    // Push until the list is full, knock twice on the full list, then read it
    // all back and drain part of it again.
    function automatic void queue_fill_sequence();
        while (planned_count < LIST_DEPTH)
            queue_cmd(ACT_PUSH, rand_index(), rand_key(), 0);
        queue_cmd(ACT_PUSH, rand_index(), rand_key(), 0);
        queue_cmd(ACT_PUSH, '1, '1, 0);
        queue_cmd(ACT_TOP, '0, '0, 0);
        queue_cmd(ACT_READ, '0, '0, RESULT_LIMIT);
        queue_cmd(ACT_SIZE, '0, '0, 0);
        for (int i = $urandom_range(1, 8); i > 0; i--)
            queue_cmd(ACT_POP, rand_index(), rand_key(), 0);
    endfunction

    function automatic void queue_directed_cmds();
        // Pop, top, read out and size on an empty list.
        queue_cmd(ACT_POP,   '0, '0, 0);
        queue_cmd(ACT_TOP,   '0, '0, 0);
        queue_cmd(ACT_READ,  '0, '0, 0);
        queue_cmd(ACT_READ,  '0, '0, RESULT_LIMIT);
        queue_cmd(ACT_SIZE,  '0, '0, 0);
        // A lone entry at the extremes of both fields, popped away again.
        queue_cmd(ACT_PUSH,  '1, '1, 0);
        queue_cmd(ACT_TOP,   '0, '0, 0);
        queue_cmd(ACT_POP,   '0, '0, 0);
        queue_cmd(ACT_TOP,   '0, '0, 0);
        // Ties with the head, a tie past the head, a new head, a new tail.
        queue_cmd(ACT_PUSH,  31'd1, 32'h10, 0);
        queue_cmd(ACT_PUSH,  31'd2, 32'h10, 0);
        queue_cmd(ACT_PUSH,  31'd3, 32'h20, 0);
        queue_cmd(ACT_PUSH,  31'd4, 32'h10, 0);
        queue_cmd(ACT_PUSH,  31'd5, 32'h20, 0);
        queue_cmd(ACT_PUSH,  31'd6, 32'h18, 0);
        queue_cmd(ACT_PUSH,  '0,    '0,     0);
        queue_cmd(ACT_PUSH,  '1,    '1,     0);
        queue_cmd(ACT_PUSH,  31'd7, 32'h7F80_0000, 0);
        // Read outs that stop short, return nothing, or hit the count.
        queue_cmd(ACT_READ,  '0, '0, 3);
        queue_cmd(ACT_READ,  '0, '0, 0);
        queue_cmd(ACT_READ,  '1, '1, RESULT_LIMIT);
        queue_cmd(ACT_POP,   '0, '0, 0);
        queue_cmd(ACT_TOP,   '0, '0, 0);
        queue_cmd(ACT_CLEAR, '0, '0, 0);
        queue_cmd(ACT_SIZE,  '0, '0, 0);
        queue_cmd(ACT_READ,  '0, '0, 1);
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A command beat is held until it is taken; between beats the
    // sender may leave gaps. Every accepted beat runs through the model at
    // once, so the owed results are queued before any of them can appear.
    // ------------------------------------------------------------------------
    list_cmd_t on_bus;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                run_list_command(on_bus);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    on_bus = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, on_bus.read_count, on_bus.key,
                                      on_bus.point_index};
                    s_axis_tuser  <= on_bus.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. The receiver stalls at random; each taken result beat is
    // compared with the oldest owed result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (owed_results.size() == 0) begin
                $error("result beat with nothing owed: tdata 0x%0h tuser %0d",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                check_field("status",      want.status,      m_axis_tuser);
                check_field("out_index",   want.out_index,   m_axis_tdata[30:0]);
                check_field("out_key",     want.out_key,     m_axis_tdata[62:31]);
                check_field("entry_count", want.entry_count, m_axis_tdata[68:63]);
                check_field("last",        want.last,        m_axis_tlast);
            end
        end
    end

    // Watchdog against a hung handshake or a lost result beat.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing of the phases.
    // ------------------------------------------------------------------------
    task automatic run_phase(int idle_pct, int stall_pct, bit with_fill);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_fill)
            queue_fill_sequence();
        queue_random_cmds(20);
        while (accepted_count != queued_count)
            @(posedge i_clk);
        while (owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed_cmds();
        run_phase(0, 0, 1'b0);
        run_phase(55, 0, 1'b1);
        run_phase(0, 55, 1'b0);
        run_phase(17, 17, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            $error("%0d result beats never arrived", owed_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sbpl_pkg.sv
design/sbpl_ctrl.sv
design/sbpl_dp.sv
design/sorted_bounded_priority_list.sv
tb/tb_sorted_bounded_priority_list.sv
